// ===== sv/lgs_pkg.sv =====
package lgs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 3'd4;

	// tile modes
	localparam logic [1:0] TILE_CLAMP  = 2'd0;
	localparam logic [1:0] TILE_REPEAT = 2'd1;
	localparam logic [1:0] TILE_MIRROR = 2'd2;

	// item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	localparam int ARGB_W = 32;
	localparam int CHAN_W = 8;

	// gradient mapping settings shared by the position stages
	typedef struct packed {
		logic signed [31:0] coef_x;
		logic signed [31:0] coef_y;
		logic signed [31:0] coef_offset;
		logic [1:0]         tile_mode;
	} coef_t;

endpackage

// ===== sv/lgs_ifs.sv =====
interface lgs_in_if #(
	parameter int COORD_BITS = 12,
	parameter int IDX_W      = 4
);
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  span_last_in;
	logic [IDX_W-1:0]      entry_index;
	logic [7:0]            entry_alpha;
	logic [7:0]            entry_red;
	logic [7:0]            entry_green;
	logic [7:0]            entry_blue;

	modport source (
		output valid, opcode, pixel_x, pixel_y, span_last_in, entry_index,
		       entry_alpha, entry_red, entry_green, entry_blue,
		input  ready
	);
	modport sink (
		input  valid, opcode, pixel_x, pixel_y, span_last_in, entry_index,
		       entry_alpha, entry_red, entry_green, entry_blue,
		output ready
	);
endinterface

interface lgs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_argb;
	logic        span_last_out;

	modport source (output valid, pixel_argb, span_last_out, input ready);
	modport sink   (input valid, pixel_argb, span_last_out, output ready);
endinterface

// ===== sv/linear_gradient_shader_top.sv =====
// Linear gradient shader, clamp / repeat / mirror tiling.
// A shade item gives its pixel after passing stages 1 to 8, from the output register; write items give none.
// Throughput: one item per cycle, set by the eight-stage pipeline; a stalled output holds stages.
// Reset: valid bits clear and registers return to zero coefficients, clamp mode, one color.
// The palette is not cleared by reset and must be written before it is used.
module linear_gradient_shader_top #(
	parameter int MAX_COLORS = 16,
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lgs_in_if.sink                         pix_in,
	lgs_out_if.source                      pix_out,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_COLORS);
	localparam int CNT_W = $clog2(MAX_COLORS + 1);

	lgs_pkg::coef_t           coef;
	logic [CNT_W-1:0]         n_intervals;
	logic                     v_s3, op_s3, span_s3;
	logic [FRAC_BITS+CNT_W:0] un_s3;
	logic [IDX_W-1:0]         eidx_s3;
	logic [31:0]              edata_s3;
	logic                     en_s4, en_s5;
	logic                     v_s4, span_s4;
	logic [31:0]              c0_s4, c1_s4;
	logic [FRAC_BITS:0]       w_s4;

	lgs_cfg #(
		.MAX_COLORS(MAX_COLORS),
		.CNT_W     (CNT_W)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.coef       (coef),
		.n_intervals(n_intervals)
	);

	lgs_pos #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.coef       (coef),
		.n_intervals(n_intervals),
		.en_s4      (en_s4),
		.v_s3       (v_s3),
		.un_s3      (un_s3),
		.op_s3      (op_s3),
		.span_s3    (span_s3),
		.eidx_s3    (eidx_s3),
		.edata_s3   (edata_s3)
	);

	lgs_pal #(
		.MAX_COLORS(MAX_COLORS),
		.FRAC_BITS (FRAC_BITS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_pal (
		.clk        (clk),
		.arst_n     (arst_n),
		.n_intervals(n_intervals),
		.v_s3       (v_s3),
		.un_s3      (un_s3),
		.op_s3      (op_s3),
		.span_s3    (span_s3),
		.eidx_s3    (eidx_s3),
		.edata_s3   (edata_s3),
		.en_s4      (en_s4),
		.en_s5      (en_s5),
		.v_s4       (v_s4),
		.c0_s4      (c0_s4),
		.c1_s4      (c1_s4),
		.w_s4       (w_s4),
		.span_s4    (span_s4)
	);

	lgs_color #(
		.FRAC_BITS(FRAC_BITS)
	) u_color (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s4   (v_s4),
		.c0_s4  (c0_s4),
		.c1_s4  (c1_s4),
		.w_s4   (w_s4),
		.span_s4(span_s4),
		.en_s5  (en_s5),
		.pix_out(pix_out)
	);

endmodule

// ===== sv/lgs_cfg.sv =====
module lgs_cfg #(
	parameter int MAX_COLORS = 16,
	parameter int CNT_W      = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output lgs_pkg::coef_t                 coef,
	output logic [CNT_W-1:0]               n_intervals
);

	lgs_pkg::coef_t   coef_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] n_next;

	// turn a color count into an interval count, zero as one, saturate at the palette size
	always_comb begin
		cnt = cfg_wdata[CNT_W-1:0];
		if (cnt == '0) begin
			n_next = '0;
		end else if (cnt > CNT_W'(MAX_COLORS)) begin
			n_next = CNT_W'(MAX_COLORS - 1);
		end else begin
			n_next = cnt - CNT_W'(1);
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			n_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lgs_pkg::REG_COEF_X:      coef_q.coef_x      <= $signed(cfg_wdata);
				lgs_pkg::REG_COEF_Y:      coef_q.coef_y      <= $signed(cfg_wdata);
				lgs_pkg::REG_COEF_OFFSET: coef_q.coef_offset <= $signed(cfg_wdata);
				lgs_pkg::REG_TILE_MODE:   coef_q.tile_mode   <= cfg_wdata[1:0];
				lgs_pkg::REG_COLOR_COUNT: n_q                <= n_next;
				default: ;
			endcase
		end
	end

	assign coef        = coef_q;
	assign n_intervals = n_q;

endmodule

// ===== sv/lgs_pos.sv =====
module lgs_pos #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lgs_in_if.sink                   pix_in,
	input  lgs_pkg::coef_t           coef,
	input  logic [CNT_W-1:0]         n_intervals,
	input  logic                     en_s4,
	output logic                     v_s3,
	output logic [FRAC_BITS+CNT_W:0] un_s3,
	output logic                     op_s3,
	output logic                     span_s3,
	output logic [IDX_W-1:0]         eidx_s3,
	output logic [31:0]              edata_s3
);

	localparam int MW  = COORD_BITS + 2;
	localparam int PW  = 32 + MW;
	localparam int SW  = PW + 2;
	localparam int UW  = FRAC_BITS + 1;
	localparam int UNW = UW + CNT_W;
	localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

	logic                 v_s1, v_s2;
	logic                 en_s1, en_s2, en_s3;
	logic signed [PW-1:0] px_s1, py_s1;
	logic                 op_s1, op_s2;
	logic                 span_s1, span_s2;
	logic [IDX_W-1:0]     eidx_s1, eidx_s2;
	logic [31:0]          edata_s1, edata_s2;
	logic [UW-1:0]        u_s2;

	logic [MW-1:0]           ox, oy;
	logic signed [SW-1:0]    sum;
	logic signed [SW-1:0]    t;
	logic [FRAC_BITS-1:0]    frac;
	logic                    ge_one;
	logic [UW-1:0]           u;

	// stage enables: a stage moves when empty or when the next one moves
	assign en_s3        = !v_s3 || en_s4;
	assign en_s2        = !v_s2 || en_s3;
	assign en_s1        = !v_s1 || en_s2;
	assign pix_in.ready = en_s1;

	// pixel centers as 2x+1, 2y+1
	assign ox = {1'b0, pix_in.pixel_x, 1'b1};
	assign oy = {1'b0, pix_in.pixel_y, 1'b1};

	// gradient position, doubled, then floored to half
	assign sum = SW'(px_s1) + SW'(py_s1) + SW'($signed({coef.coef_offset, 1'b0}));
	assign t   = sum >>> 1;
	assign frac   = t[FRAC_BITS-1:0];
	assign ge_one = !t[SW-1] && (|t[SW-1:FRAC_BITS]);

	// tile into 0..1
	always_comb begin
		case (coef.tile_mode)
			lgs_pkg::TILE_REPEAT: u = {1'b0, frac};
			lgs_pkg::TILE_MIRROR: u = t[FRAC_BITS] ? (ONE - {1'b0, frac}) : {1'b0, frac};
			default: begin
				if (t[SW-1]) begin
					u = '0;
				end else if (ge_one) begin
					u = ONE;
				end else begin
					u = {1'b0, frac};
				end
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: coefficient products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1    <= coef.coef_x * $signed(ox);
			py_s1    <= coef.coef_y * $signed(oy);
			op_s1    <= pix_in.opcode;
			span_s1  <= pix_in.span_last_in;
			eidx_s1  <= pix_in.entry_index;
			edata_s1 <= {pix_in.entry_alpha, pix_in.entry_red,
			             pix_in.entry_green, pix_in.entry_blue};
		end
	end

	// stage 2: sum and tile
	always_ff @(posedge clk) begin
		if (en_s2) begin
			u_s2     <= u;
			op_s2    <= op_s1;
			span_s2  <= span_s1;
			eidx_s2  <= eidx_s1;
			edata_s2 <= edata_s1;
		end
	end

	// stage 3: scale by the interval count
	always_ff @(posedge clk) begin
		if (en_s3) begin
			un_s3    <= UNW'(u_s2) * UNW'(n_intervals);
			op_s3    <= op_s2;
			span_s3  <= span_s2;
			eidx_s3  <= eidx_s2;
			edata_s3 <= edata_s2;
		end
	end

endmodule

// ===== sv/lgs_pal.sv =====
module lgs_pal #(
	parameter int MAX_COLORS = 16,
	parameter int FRAC_BITS  = 16,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CNT_W-1:0]         n_intervals,
	input  logic                     v_s3,
	input  logic [FRAC_BITS+CNT_W:0] un_s3,
	input  logic                     op_s3,
	input  logic                     span_s3,
	input  logic [IDX_W-1:0]         eidx_s3,
	input  logic [31:0]              edata_s3,
	output logic                     en_s4,
	input  logic                     en_s5,
	output logic                     v_s4,
	output logic [31:0]              c0_s4,
	output logic [31:0]              c1_s4,
	output logic [FRAC_BITS:0]       w_s4,
	output logic                     span_s4
);

	localparam int UW = FRAC_BITS + 1;
	localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

	logic [31:0] mem [MAX_COLORS];

	logic [CNT_W:0]   q;
	logic [CNT_W-1:0] idx;
	logic [UW-1:0]    w;
	logic [IDX_W-1:0] ra0, ra1;
	logic             wr_ok;

	assign en_s4 = !v_s4 || en_s5;

	// interval index and weight; the top of the range uses the last interval at full weight
	assign q = un_s3[FRAC_BITS+CNT_W:FRAC_BITS];
	always_comb begin
		if (n_intervals == '0) begin
			idx = '0;
			w   = '0;
		end else if (q >= {1'b0, n_intervals}) begin
			idx = n_intervals - CNT_W'(1);
			w   = ONE;
		end else begin
			idx = q[CNT_W-1:0];
			w   = {1'b0, un_s3[FRAC_BITS-1:0]};
		end
	end

	// a single color reads its one entry on both ports
	assign ra0   = idx[IDX_W-1:0];
	assign ra1   = (n_intervals == '0) ? ra0 : (ra0 + IDX_W'(1));
	assign wr_ok = {1'b0, eidx_s3} < (IDX_W+1)'(MAX_COLORS);

	// palette write and read, in item order
	always_ff @(posedge clk) begin
		if (en_s4) begin
			if (v_s3 && (op_s3 == lgs_pkg::OP_WRITE) && wr_ok) begin
				mem[eidx_s3] <= edata_s3;
			end
			c0_s4 <= mem[ra0];
			c1_s4 <= mem[ra1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			w_s4    <= w;
			span_s4 <= span_s3;
		end
	end

	// drop write items here, they give no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3 && (op_s3 == lgs_pkg::OP_SHADE);
		end
	end

endmodule

// ===== sv/lgs_color.sv =====
module lgs_color #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_s4,
	input  logic [31:0]        c0_s4,
	input  logic [31:0]        c1_s4,
	input  logic [FRAC_BITS:0] w_s4,
	input  logic               span_s4,
	output logic               en_s5,
	lgs_out_if.source          pix_out
);

	localparam int UW  = FRAC_BITS + 1;
	localparam int CHW = FRAC_BITS + 8;
	localparam int MPW = FRAC_BITS + 9;
	localparam int NW  = 2 * CHW;
	localparam logic [UW-1:0]  ONE      = UW'(1) << FRAC_BITS;
	localparam logic [MPW-1:0] HALF     = MPW'(1) << (FRAC_BITS - 1);
	localparam logic [NW-1:0]  DEN_HALF = NW'(255) << (2 * FRAC_BITS - 1);

	logic v_s5, v_s6, v_s7;
	logic en_s6, en_s7, en_s8;

	logic [CHW-1:0] ch_s5 [4];
	logic [NW-1:0]  num_s6 [3];
	logic [15:0]    h_s7 [3];
	logic [7:0]     alpha_s6, alpha_s7;
	logic           span_s5, span_s6, span_s7;

	logic [CHW-1:0] ch [4];
	logic [MPW-1:0] m0, m1;
	logic [UW-1:0]  wc;
	logic [MPW-1:0] asum;
	logic [NW-1:0]  rnd [3];
	logic [7:0]     quo [3];
	logic [23:0]    hm;
	logic [7:0]     q0;
	logic [15:0]    rem;

	assign en_s8         = !pix_out.valid || pix_out.ready;
	assign en_s7         = !v_s7 || en_s8;
	assign en_s6         = !v_s6 || en_s7;
	assign en_s5         = !v_s5 || en_s6;

	// blend the two entries per channel
	always_comb begin
		wc = ONE - w_s4;
		m0 = '0;
		m1 = '0;
		for (int k = 0; k < 4; k++) begin
			m0    = MPW'(c0_s4[31-8*k -: 8]) * MPW'(wc);
			m1    = MPW'(c1_s4[31-8*k -: 8]) * MPW'(w_s4);
			ch[k] = CHW'(m0 + m1);
		end
	end

	// alpha rounding, color rounding offsets
	assign asum = MPW'(ch_s5[0]) + HALF;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd[k] = num_s6[k] + DEN_HALF;
		end
	end

	// divide by 255 through the reciprocal, then correct once
	always_comb begin
		hm  = '0;
		q0  = '0;
		rem = '0;
		for (int k = 0; k < 3; k++) begin
			hm  = 24'(h_s7[k]) * 24'(257);
			q0  = hm[23:16];
			rem = h_s7[k] - 16'(q0) * 16'(255);
			quo[k] = (rem >= 16'(255)) ? (q0 + 8'd1) : q0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5          <= 1'b0;
			v_s6          <= 1'b0;
			v_s7          <= 1'b0;
			pix_out.valid <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) pix_out.valid <= v_s7;
		end
	end

	// stage 5: blended channels
	always_ff @(posedge clk) begin
		if (en_s5) begin
			ch_s5   <= ch;
			span_s5 <= span_s4;
		end
	end

	// stage 6: premultiply by alpha
	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int k = 0; k < 3; k++) begin
				num_s6[k] <= NW'(ch_s5[0]) * NW'(ch_s5[k+1]);
			end
			alpha_s6 <= asum[FRAC_BITS+7:FRAC_BITS];
			span_s6  <= span_s5;
		end
	end

	// stage 7: round and drop the fraction
	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int k = 0; k < 3; k++) begin
				h_s7[k] <= rnd[k][NW-1:2*FRAC_BITS];
			end
			alpha_s7 <= alpha_s6;
			span_s7  <= span_s6;
		end
	end

	// stage 8: pack the pixel into the output register
	always_ff @(posedge clk) begin
		if (en_s8) begin
			pix_out.pixel_argb    <= {alpha_s7, quo[0], quo[1], quo[2]};
			pix_out.span_last_out <= span_s7;
		end
	end

endmodule
